// File: rtl/bicb_pkg.sv
// ---------------------------------------------------------------------------
// bicb_pkg: shared types and constants for the box-in-brush test
// Operation codes, fixed-point format constants and the product bundle
// passed from the multiply stage to the plane evaluation.
// ---------------------------------------------------------------------------
package bicb_pkg;

	localparam int MAX_SIDES        = 256;
	localparam int NORMAL_FRAC_BITS = 16;
	localparam int SIDE_CNT_W       = $clog2(MAX_SIDES + 1);

	typedef enum logic [2:0] {
		OP_QUERY  = 3'd0,
		OP_BOUNDS = 3'd1,
		OP_CORNER = 3'd2,
		OP_HEADER = 3'd3,
		OP_SIDE   = 3'd4
	} op_t;

	typedef logic signed [31:0] coord_t;

	// per-axis products of one side plane, registered after the multipliers
	typedef struct packed {
		logic signed [64:0] pn_x;     // (start [+ corner]) * n
		logic signed [64:0] pn_y;
		logic signed [64:0] pn_z;
		logic signed [63:0] on_x;     // sphere offset * n
		logic signed [63:0] on_y;
		logic signed [63:0] on_z;
		logic signed [32:0] dist_sum; // plane distance, plus radius in capsule mode
		logic               sphere;
	} plane_prod_t;

endpackage

// File: rtl/bicb_plane_eval.sv
// ---------------------------------------------------------------------------
// bicb_plane_eval: side plane distance sign
// Sums the registered products exactly and flags a test point that lies
// strictly in front of the plane.
// ---------------------------------------------------------------------------
module bicb_plane_eval (
	input  bicb_pkg::plane_prod_t prod,
	output logic                  in_front
);

	logic signed [67:0] sum_p;
	logic signed [67:0] sum_o;
	logic signed [67:0] off_term;
	logic signed [67:0] dist_term;
	logic signed [67:0] total;
	logic               off_front;

	always_comb begin
		sum_p = 68'($signed(prod.pn_x)) + 68'($signed(prod.pn_y)) + 68'($signed(prod.pn_z));
		sum_o = 68'($signed(prod.on_x)) + 68'($signed(prod.on_y)) + 68'($signed(prod.on_z));
		off_front = (sum_o > 68'sd0);
		// capsule: test point is start minus offset when offset faces the normal
		if (prod.sphere) begin
			off_term = off_front ? -sum_o : sum_o;
		end else begin
			off_term = '0;
		end
		dist_term = 68'($signed(prod.dist_sum)) <<< bicb_pkg::NORMAL_FRAC_BITS;
		total     = sum_p + off_term - dist_term;
		in_front  = (total > 68'sd0);
	end

endmodule

// File: rtl/box_in_convex_brush_test_top.sv
// ---------------------------------------------------------------------------
// box_in_convex_brush_test_top: box or capsule inside convex brush test
// Streams query, corner, brush header and side plane beats; gives one
// verdict beat per brush.
// ---------------------------------------------------------------------------
// The block takes one item beat per clock and gives one verdict per brush.
// Each beat is registered (s1), where query, bounds and corner beats update
// the query state and a side beat runs its six multipliers (start plus
// corner, or start and sphere offset, against the plane normal). The
// products are registered (s2), summed exactly and compared against the
// plane distance; brush state (overlap, all-behind flag, side countdown,
// contents) lives at s2. A verdict leaves through the result register once
// the beat that closes the brush has passed s1 and s2: the last side beat,
// or the header beat itself when the side count is zero. Sustained rate is
// one beat per cycle; item_stall rises only when a verdict is held up by
// result_stall with both stages full. Side counts above 256 are clamped.
// Sides with no brush pending and unknown operation codes are dropped;
// a new header abandons an unfinished brush without a verdict.
// ---------------------------------------------------------------------------
module box_in_convex_brush_test_top (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  operation,
	input  logic [31:0] vec_a_x,
	input  logic [31:0] vec_a_y,
	input  logic [31:0] vec_a_z,
	input  logic [31:0] vec_b_x,
	input  logic [31:0] vec_b_y,
	input  logic [31:0] vec_b_z,
	input  logic [31:0] scalar_value,
	input  logic [8:0]  count_or_index,
	input  logic        use_sphere,
	input  logic [31:0] brush_flags,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        inside_solid,
	output logic [31:0] solid_contents
);

	localparam int CW = bicb_pkg::SIDE_CNT_W;

	// ---------------- stage 1: registered item beat ----------------
	logic                  s1_v_s1;
	logic [2:0]            op_s1;
	bicb_pkg::coord_t      a_s1 [3];
	bicb_pkg::coord_t      b_s1 [3];
	bicb_pkg::coord_t      scalar_s1;
	logic [8:0]            cnt_s1;
	logic                  sph_s1;
	logic [31:0]           flags_s1;

	// query state, updated as beats leave s1
	bicb_pkg::coord_t      start_q  [3];
	bicb_pkg::coord_t      offset_q [3];
	bicb_pkg::coord_t      qmin_q   [3];
	bicb_pkg::coord_t      qmax_q   [3];
	bicb_pkg::coord_t      radius_q;
	logic                  sphere_q;
	bicb_pkg::coord_t      corner_q [8][3];   // no reset: undefined until written

	// ---------------- stage 2: products and brush control ----------------
	logic                  s2_v_s2;
	logic                  is_hdr_s2;
	bicb_pkg::plane_prod_t prod_s2;
	logic                  overlap_s2;
	logic [CW-1:0]         cnt_s2;
	logic [31:0]           flags_s2;

	// brush state
	logic                  overlap_q;
	logic                  behind_q;
	logic [CW-1:0]         sides_rem_q;
	logic [31:0]           held_q;

	// result register
	logic                  result_valid_q;
	logic                  inside_q;
	logic [31:0]           contents_q;

	// flow control
	logic                  accept;
	logic                  out_free;
	logic                  s2_emit;
	logic                  s2_go;
	logic                  s2_free;
	logic                  s1_go;
	logic                  s1_to_s2;

	// s1 datapath
	logic                  overlap_c;
	logic [CW-1:0]         cnt_sat_c;
	bicb_pkg::plane_prod_t prod_c;
	logic signed [32:0]    pv_c [3];
	logic [2:0]            cidx;

	// s2 datapath
	logic                  in_front;
	logic                  side_live;
	logic                  inside_c;

	assign cidx = cnt_s1[2:0];

	// ---------------- handshake ----------------
	assign out_free   = !result_valid_q || !result_stall;
	assign side_live  = (sides_rem_q != '0);
	assign s2_emit    = s2_v_s2 && (is_hdr_s2 ? (cnt_s2 == '0)
	                                          : (side_live && sides_rem_q == CW'(1)));
	assign s2_go      = s2_v_s2 && (!s2_emit || out_free);
	assign s2_free    = !s2_v_s2 || s2_go;
	assign s1_go      = s1_v_s1 && s2_free;
	assign s1_to_s2   = (op_s1 == bicb_pkg::OP_HEADER) || (op_s1 == bicb_pkg::OP_SIDE);
	assign item_stall = s1_v_s1 && !s2_free;
	assign accept     = item_valid && !item_stall;

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
		end else if (accept) begin
			s1_v_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			a_s1[0]   <= vec_a_x;
			a_s1[1]   <= vec_a_y;
			a_s1[2]   <= vec_a_z;
			b_s1[0]   <= vec_b_x;
			b_s1[1]   <= vec_b_y;
			b_s1[2]   <= vec_b_z;
			scalar_s1 <= scalar_value;
			cnt_s1    <= count_or_index;
			sph_s1    <= use_sphere;
			flags_s1  <= brush_flags;
		end
	end

	// query state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				start_q[i]  <= '0;
				offset_q[i] <= '0;
				qmin_q[i]   <= '0;
				qmax_q[i]   <= '0;
			end
			radius_q <= '0;
			sphere_q <= 1'b0;
		end else if (s1_go) begin
			if (op_s1 == bicb_pkg::OP_QUERY) begin
				for (int i = 0; i < 3; i++) begin
					start_q[i]  <= a_s1[i];
					offset_q[i] <= b_s1[i];
				end
				radius_q <= scalar_s1;
				sphere_q <= sph_s1;
			end else if (op_s1 == bicb_pkg::OP_BOUNDS) begin
				for (int i = 0; i < 3; i++) begin
					qmin_q[i] <= a_s1[i];
					qmax_q[i] <= b_s1[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && op_s1 == bicb_pkg::OP_CORNER) begin
			for (int i = 0; i < 3; i++) begin
				corner_q[cidx][i] <= a_s1[i];
			end
		end
	end

	// header: bounds overlap and clamped side count
	always_comb begin
		overlap_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (qmin_q[i] > b_s1[i] || a_s1[i] > qmax_q[i]) begin
				overlap_c = 1'b0;
			end
		end
		cnt_sat_c = (32'(cnt_s1) > 32'(bicb_pkg::MAX_SIDES)) ? CW'(bicb_pkg::MAX_SIDES)
		                                                     : CW'(cnt_s1);
	end

	// side: products against the normal in a_s1
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sphere_q) begin
				pv_c[i] = 33'(start_q[i]);
			end else begin
				pv_c[i] = 33'(start_q[i]) + 33'(corner_q[cidx][i]);
			end
		end
		prod_c.pn_x     = 65'(pv_c[0]) * 65'(a_s1[0]);
		prod_c.pn_y     = 65'(pv_c[1]) * 65'(a_s1[1]);
		prod_c.pn_z     = 65'(pv_c[2]) * 65'(a_s1[2]);
		prod_c.on_x     = 64'(offset_q[0]) * 64'(a_s1[0]);
		prod_c.on_y     = 64'(offset_q[1]) * 64'(a_s1[1]);
		prod_c.on_z     = 64'(offset_q[2]) * 64'(a_s1[2]);
		prod_c.dist_sum = sphere_q ? (33'(scalar_s1) + 33'(radius_q)) : 33'(scalar_s1);
		prod_c.sphere   = sphere_q;
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_s2 <= 1'b0;
		end else if (s1_go) begin
			s2_v_s2 <= s1_to_s2;
		end else if (s2_go) begin
			s2_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			is_hdr_s2  <= (op_s1 == bicb_pkg::OP_HEADER);
			prod_s2    <= prod_c;
			overlap_s2 <= overlap_c;
			cnt_s2     <= cnt_sat_c;
			flags_s2   <= flags_s1;
		end
	end

	bicb_plane_eval u_eval (
		.prod     (prod_s2),
		.in_front (in_front)
	);

	assign inside_c = is_hdr_s2 ? overlap_s2 : (overlap_q && behind_q && !in_front);

	// brush state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_q   <= 1'b0;
			behind_q    <= 1'b0;
			sides_rem_q <= '0;
			held_q      <= '0;
		end else if (s2_go) begin
			if (is_hdr_s2) begin
				overlap_q   <= overlap_s2;
				behind_q    <= 1'b1;
				sides_rem_q <= cnt_s2;
				held_q      <= flags_s2;
			end else if (side_live) begin
				behind_q    <= behind_q && !in_front;
				sides_rem_q <= sides_rem_q - CW'(1);
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s2_go && s2_emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && s2_emit) begin
			inside_q   <= inside_c;
			contents_q <= inside_c ? (is_hdr_s2 ? flags_s2 : held_q) : 32'd0;
		end
	end

	assign result_valid   = result_valid_q;
	assign inside_solid   = inside_q;
	assign solid_contents = contents_q;

	// ---------------- assertions ----------------
	// a side verdict only on the last side of a live brush
	a_side_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && s2_emit && !is_hdr_s2) |-> (sides_rem_q == CW'(1)))
		else $error("side verdict without last pending side");

	// side countdown never exceeds the clamp
	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sides_rem_q) <= 32'(bicb_pkg::MAX_SIDES))
		else $error("side countdown above limit");

	// a blocked s2 beat holds its kind and stays valid
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_s2 && !s2_go) |=> (s2_v_s2 && $stable(is_hdr_s2) && $stable(cnt_s2)))
		else $error("s2 beat changed while blocked");

	// a verdict is never dropped: emission only when the result register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && s2_emit) |-> out_free)
		else $error("verdict would overwrite held result");

endmodule
